// ===== design/tkl_pkg.sv =====
// Shared types, constants and helpers for the top-k largest tracker.
`default_nettype none

package tkl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] item_size;
        logic [31:0] item_tag;
        logic [3:0]  read_rank;
    } in_item_t;

    typedef struct packed {
        logic [63:0] rank_size;
        logic [31:0] rank_tag;
        logic        rank_valid;
        logic        was_kept;
        logic [4:0]  entry_count;
        logic [63:0] least_kept_size;
    } out_item_t;

    typedef struct packed {
        logic [63:0] size;
        logic [31:0] tag;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_ADDR,
        ST_INS_CMP,
        ST_FULL_ADDR,
        ST_FULL_CMP,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_LAST_ADDR,
        ST_LAST_DATA,
        ST_DONE
    } state_t;

    // Limit as used by the list: zero acts as one, and the limit saturates at the depth.
    function automatic logic [CNT_W-1:0] eff_limit(input logic [4:0] v);
        logic [CNT_W-1:0] r;
        if (v == 5'd0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > MAX_ENTRIES)
        begin
            r = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tkl_store.sv =====
// Entry storage: one write port and one read port with registered read data.
`default_nettype none

module tkl_store
    import tkl_pkg::*;
(
    input  wire logic             clk,
    input  wire wr_req_t          wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/top_k_largest_tracker_unit.sv =====
// Top level of the top-k largest tracker: sequencer, shared comparator and output register.
`default_nettype none

// Keeps the largest sizes seen, sorted in descending order with a tag each, in a
// single-port-read entry memory. An insert walks up from the end of the list with one
// shared 64-bit comparator, moving each entry that is not larger than the new size down
// by one; every step has an address state and a compare state because the memory read
// is registered. A full list first checks the last entry, and an item that does not
// beat it is dropped. A read of a rank past the end skips the data fetch. Every item on
// a non-empty list ends with one extra memory read to fetch the smallest kept size. The
// block takes one item at a time and is ready again in the cycle after its result is
// loaded, unless a limit write is waiting; the finished result sits in an output
// register, so the next item may be taken while it waits. The limit register is written
// only while the block is idle; lowering it drops the tail entries at once. No clearing
// pass is needed after reset.

module top_k_largest_tracker_unit
    import tkl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [4:0] cfg_data
);

    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [4:0]        keep_limit_reg, keep_limit_next;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  held_dec;
    logic [CNT_W-1:0]  lim_dec;
    logic              rank_ok;
    logic              larger;
    logic              in_xfer;
    logic              cfg_xfer;
    wr_req_t           wr;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    entry_t            new_entry;

    tkl_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign lim       = eff_limit(keep_limit_reg);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign held_dec  = held_reg - CNT_W'(1);
    assign lim_dec   = lim - CNT_W'(1);
    assign rank_ok   = (32'(item_reg.read_rank) < 32'(held_reg))
                       && (32'(item_reg.read_rank) < 32'(MAX_ENTRIES));
    assign larger    = rd_data.size > item_reg.item_size;
    assign new_entry = '{size: item_reg.item_size, tag: item_reg.item_tag};

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.func == FUNC_READ)
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else if (held_reg < lim)
                    begin
                        state_next = ST_INS_ADDR;
                    end
                    else
                    begin
                        state_next = ST_FULL_ADDR;
                    end
                end
            end
            ST_INS_ADDR:
            begin
                state_next = (idx_reg == '0) ? ST_LAST_ADDR : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = larger ? ST_LAST_ADDR : ST_INS_ADDR;
            end
            ST_FULL_ADDR:
            begin
                state_next = ST_FULL_CMP;
            end
            ST_FULL_CMP:
            begin
                state_next = larger ? ST_LAST_ADDR : ST_INS_ADDR;
            end
            ST_RD_ADDR:
            begin
                state_next = rank_ok ? ST_RD_DATA : ST_LAST_ADDR;
            end
            ST_RD_DATA:
            begin
                state_next = ST_LAST_ADDR;
            end
            ST_LAST_ADDR:
            begin
                state_next = (held_reg == '0) ? ST_DONE : ST_LAST_DATA;
            end
            ST_LAST_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next       = item_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        keep_limit_next = keep_limit_reg;
        wr              = '{en: 1'b0, addr: '0, data: '0};
        rd_addr         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_xfer)
                begin
                    keep_limit_next = cfg_data;
                    if (held_reg > eff_limit(cfg_data))
                    begin
                        held_next = eff_limit(cfg_data);
                    end
                end
                if (in_xfer)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    idx_next  = held_reg;
                end
            end
            ST_INS_ADDR:
            begin
                if (idx_reg == '0)
                begin
                    wr = '{en: 1'b1, addr: '0, data: new_entry};
                    res_next.was_kept = 1'b1;
                    if (held_reg < lim)
                    begin
                        held_next = held_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    rd_addr = idx_dec[IDX_W-1:0];
                end
            end
            ST_INS_CMP:
            begin
                if (larger)
                begin
                    wr = '{en: 1'b1, addr: idx_reg[IDX_W-1:0], data: new_entry};
                    res_next.was_kept = 1'b1;
                    if (held_reg < lim)
                    begin
                        held_next = held_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    // Not larger than the new size: this entry moves down one rank.
                    wr = '{en: 1'b1, addr: idx_reg[IDX_W-1:0], data: rd_data};
                    idx_next = idx_dec;
                end
            end
            ST_FULL_ADDR:
            begin
                rd_addr = lim_dec[IDX_W-1:0];
            end
            ST_FULL_CMP:
            begin
                // When the new item beats the last entry, that entry is overwritten.
                if (!larger)
                begin
                    idx_next = lim_dec;
                end
            end
            ST_RD_ADDR:
            begin
                rd_addr = item_reg.read_rank[IDX_W-1:0];
            end
            ST_RD_DATA:
            begin
                res_next.rank_size  = rd_data.size;
                res_next.rank_tag   = rd_data.tag;
                res_next.rank_valid = 1'b1;
            end
            ST_LAST_ADDR:
            begin
                rd_addr = held_dec[IDX_W-1:0];
            end
            ST_LAST_DATA:
            begin
                res_next.least_kept_size = rd_data.size;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next             = res_reg;
                    out_data_next.entry_count = 5'(held_reg);
                    out_valid_next            = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            held_reg       <= '0;
            keep_limit_reg <= 5'd16;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            held_reg       <= held_next;
            keep_limit_reg <= keep_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        idx_reg      <= idx_next;
    end

endmodule

`default_nettype wire

// ===== design/tkl_checker.sv =====
// Port-level checks for the top-k largest tracker, bound to the top level.
`default_nettype none

module tkl_checker
    import tkl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire out_item_t  out_data
);

    // A result that waits must hold still until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One item at a time: the block is busy right after taking an item.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.entry_count) <= MAX_ENTRIES)
        else $error("entry count beyond depth");

    // A result reports either a read hit or a kept insert, never both.
    a_read_or_insert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rank_valid |-> !out_data.was_kept)
        else $error("read and insert flags both set");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.entry_count == 5'd0
            |-> out_data.least_kept_size == 64'd0 && !out_data.rank_valid
                && !out_data.was_kept)
        else $error("empty list reports an entry");

endmodule

bind top_k_largest_tracker_unit tkl_checker u_tkl_checker (.*);

`default_nettype wire

// ===== test/tb_top_k_largest_tracker_unit.sv =====
// Self-checking testbench for the top-k largest tracker: random and directed traffic.
`timescale 1ns / 1ps

module tb_top_k_largest_tracker_unit;
    import tkl_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int RANDOM_PHASES = 10;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;

    // Software copy of the ranked list and its limit.
    logic [63:0] ranked_size_copy [MAX_ENTRIES];
    logic [31:0] ranked_tag_copy [MAX_ENTRIES];
    int unsigned held_copy = 0;
    logic [4:0] limit_copy = 5'd16;

    in_item_t items_to_send [$];
    out_item_t awaited_results [$];
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned insert_count = 0;
    int unsigned read_count = 0;
    int unsigned kept_count = 0;
    int unsigned rejected_count = 0;
    int unsigned read_hits = 0;
    int unsigned limit_writes = 0;
    int unsigned deepest_list = 0;

    bit sender_gaps = 1'b0;
    bit receiver_gaps = 1'b0;
    bit hold_request = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    top_k_largest_tracker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned limit_in_force();
        int unsigned lim;
        lim = limit_copy;
        if (lim == 0)
        begin
            lim = 1;
        end
        else if (lim > MAX_ENTRIES)
        begin
            lim = MAX_ENTRIES;
        end
        return lim;
    endfunction

    // Updates the list copy for one accepted item and queues the result it must give.
    task automatic apply_to_ranking(input in_item_t it);
        out_item_t res;
        int unsigned lim;
        int unsigned pos;
        int unsigned last;
        res = '0;
        if (it.func == FUNC_INSERT)
        begin
            insert_count++;
            lim = limit_in_force();
            pos = 0;
            while (pos < held_copy && ranked_size_copy[pos] > it.item_size)
            begin
                pos++;
            end
            if (pos < lim)
            begin
                last = (held_copy < lim) ? held_copy : lim - 1;
                for (int unsigned i = last; i > pos; i--)
                begin
                    ranked_size_copy[i] = ranked_size_copy[i - 1];
                    ranked_tag_copy[i] = ranked_tag_copy[i - 1];
                end
                ranked_size_copy[pos] = it.item_size;
                ranked_tag_copy[pos] = it.item_tag;
                if (held_copy < lim)
                begin
                    held_copy++;
                end
                res.was_kept = 1'b1;
                kept_count++;
            end
            else
            begin
                rejected_count++;
            end
        end
        else
        begin
            read_count++;
            if (it.read_rank < held_copy)
            begin
                res.rank_size = ranked_size_copy[it.read_rank];
                res.rank_tag = ranked_tag_copy[it.read_rank];
                res.rank_valid = 1'b1;
                read_hits++;
            end
        end
        res.entry_count = 5'(held_copy);
        res.least_kept_size = (held_copy == 0) ? 64'd0 : ranked_size_copy[held_copy - 1];
        if (held_copy > deepest_list)
        begin
            deepest_list = held_copy;
        end
        awaited_results.push_back(res);
        items_taken++;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    // Sender: one item at a time from the queue, with a random gap after each when sender gaps are on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_to_ranking(in_data);
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (items_to_send.size() != 0)
                begin
                    in_data <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_wait = sender_gaps ? $urandom_range(0, 9) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer and stalls at random or on request.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got %0h",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.rank_size !== want.rank_size)
                        note_mismatch("rank_size", want.rank_size, out_data.rank_size);
                    if (out_data.rank_tag !== want.rank_tag)
                        note_mismatch("rank_tag", want.rank_tag, out_data.rank_tag);
                    if (out_data.rank_valid !== want.rank_valid)
                        note_mismatch("rank_valid", want.rank_valid, out_data.rank_valid);
                    if (out_data.was_kept !== want.was_kept)
                        note_mismatch("was_kept", want.was_kept, out_data.was_kept);
                    if (out_data.entry_count !== want.entry_count)
                        note_mismatch("entry_count", want.entry_count, out_data.entry_count);
                    if (out_data.least_kept_size !== want.least_kept_size)
                        note_mismatch("least_kept_size", want.least_kept_size,
                                      out_data.least_kept_size);
                    results_checked++;
                end
                recv_wait = receiver_gaps ? $urandom_range(0, 9) : 0;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top_k_largest_tracker_unit NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic func, input logic [63:0] size,
                              input logic [31:0] tag, input logic [3:0] rank);
        in_item_t it;
        it.func = func;
        it.item_size = size;
        it.item_tag = tag;
        it.read_rank = rank;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        it.func = ($urandom_range(0, 99) < 60) ? FUNC_INSERT : FUNC_READ;
        case ($urandom_range(0, 9))
            6, 7:    it.item_size = {$urandom, $urandom};
            8:       it.item_size = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            9:       it.item_size = 64'd1 << $urandom_range(0, 63);
            default: it.item_size = 64'($urandom_range(0, 24));
        endcase
        it.item_tag = $urandom;
        it.read_rank = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
        begin
            items_to_send.push_back(random_item());
            items_queued++;
        end
    endtask

    // Waits until every queued item has been taken and every result has come back.
    task automatic wait_for_drain();
        while (items_taken != items_queued || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_keep_limit(input logic [4:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        limit_copy = value;
        if (held_copy > limit_in_force())
        begin
            held_copy = limit_in_force();
        end
        limit_writes++;
    endtask

    initial
    begin
        logic [4:0] phase_limits [RANDOM_PHASES];
        phase_limits = '{5'd17, 5'd16, 5'd1, 5'd5, 5'd2, 5'd0, 5'd9, 5'd31, 5'd12, 5'd16};
        phase_limits[RANDOM_PHASES - 1] = 5'($urandom_range(1, 16));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list reads, extremes, equal sizes including a tie with the top entry.
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd0);
        queue_item(FUNC_READ, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        queue_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
        queue_item(FUNC_INSERT, 64'd0, 32'd0, 4'd15);
        queue_item(FUNC_INSERT, 64'd5, 32'h0000_000A, 4'd0);
        queue_item(FUNC_INSERT, 64'd5, 32'h0000_000B, 4'd0);
        queue_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_000C, 4'd0);
        for (int r = 0; r <= 5; r++)
        begin
            queue_item(FUNC_READ, 64'd0, 32'd0, 4'(r));
        end
        wait_for_drain();

        // Lowering the limit clips the list; then a full list meets small and equal sizes.
        write_keep_limit(5'd3);
        queue_item(FUNC_INSERT, 64'd1, 32'h0000_0011, 4'd0);
        queue_item(FUNC_INSERT, 64'd5, 32'h0000_000D, 4'd0);
        queue_item(FUNC_INSERT, 64'd0, 32'h0000_0012, 4'd0);
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd0);
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd1);
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd3);
        wait_for_drain();

        // A zero limit acts as one.
        write_keep_limit(5'd0);
        queue_item(FUNC_INSERT, 64'd7, 32'h0000_000E, 4'd0);
        queue_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_000F, 4'd0);
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd0);
        wait_for_drain();

        // A limit above the depth saturates.
        write_keep_limit(5'd31);
        queue_item(FUNC_INSERT, 64'd9, 32'h0000_0010, 4'd0);
        queue_item(FUNC_READ, 64'd0, 32'd0, 4'd1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_for_drain();
            write_keep_limit(phase_limits[p]);
            sender_gaps = (p % 3 != 0);
            receiver_gaps = (p % 4 != 1);
            if (p == 4)
            begin
                // The sender stops halfway until everything outstanding has come back.
                queue_random(ITEMS_PER_PHASE / 2);
                wait_for_drain();
                queue_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end
            else
            begin
                queue_random(ITEMS_PER_PHASE);
                if (p == 2)
                begin
                    hold_request = 1'b1;
                end
            end
        end

        wait_for_drain();
        repeat (60) @(posedge clk);
        $display("Checked %0d results: %0d inserts (%0d kept, %0d dropped), %0d reads (%0d hits).",
                 results_checked, insert_count, kept_count, rejected_count, read_count,
                 read_hits);
        $display("Limit written %0d times, deepest list %0d entries.", limit_writes,
                 deepest_list);
        if (mismatches == 0 && awaited_results.size() == 0)
        begin
            $display("tb_top_k_largest_tracker_unit OK");
        end
        else
        begin
            $display("tb_top_k_largest_tracker_unit NOT OK");
        end
        $finish;
    end

endmodule
